// ----- hw/rtl/cptp_pkg.sv -----
// shared types, constants and the sequencer microprogram for the task picker
// no dependencies; imported by cptp_seq, cptp_dp, the core and the bench
package cptp_pkg;

	localparam int MAX_TASKS_DEF = 64;

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SCHED = 1'b1;

	typedef struct packed {
		logic       command;
		logic [5:0] task_index;
		logic       task_present;
		logic       task_started;
		logic [6:0] task_priority;
		logic [7:0] task_counter;
	} cmd_t;

	typedef struct packed {
		logic [5:0] chosen_task;
		logic       switched;
		logic       none_runnable;
		logic       recomputed;
	} res_t;

	// one task table entry as stored in the ram
	typedef struct packed {
		logic       present;
		logic       started;
		logic [6:0] prio;
		logic [7:0] counter;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);
	localparam slot_t SLOT_RESET = '{present: 1'b0, started: 1'b0,
		prio: 7'd1, counter: 8'd0};

	// microprogram addresses
	typedef logic [2:0] step_t;
	localparam step_t ST_IDLE   = 3'd0;
	localparam step_t ST_SCAN   = 3'd1;
	localparam step_t ST_CHECK  = 3'd2;
	localparam step_t ST_EMIT   = 3'd3;
	localparam step_t ST_RINIT  = 3'd4;
	localparam step_t ST_RECOMP = 3'd5;
	localparam step_t ST_RESCAN = 3'd6;

	typedef enum logic [2:0] {
		J_NEXT,    // fall through
		J_ALWAYS,  // go to target
		J_START,   // go to target on a schedule beat, else hold
		J_LOOP,    // hold while slots remain, else fall through
		J_RECOMP,  // go to target when a started task exists, all started counters are zero and no recompute has run yet
		J_OUT      // go to target once the result register is free
	} jcond_t;

	typedef struct packed {
		logic   idle;
		logic   clr_i;
		logic   scan;
		logic   eval;
		logic   wback;
		logic   clr_best;
		logic   set_recomp;
		logic   clr_recomp;
		logic   emit;
		jcond_t jcond;
		step_t  target;
	} ctrl_word_t;

	typedef struct packed {
		logic more;
		logic need_recomp;
		logic out_free;
	} status_t;

	localparam ctrl_word_t CW_NOP = '{idle: 1'b0, clr_i: 1'b0, scan: 1'b0,
		eval: 1'b0, wback: 1'b0, clr_best: 1'b0, set_recomp: 1'b0,
		clr_recomp: 1'b0, emit: 1'b0, jcond: J_ALWAYS, target: ST_IDLE};

	function automatic ctrl_word_t ucode_rom(step_t s);
		ctrl_word_t w;
		w = CW_NOP;
		case (s)
			ST_IDLE: begin
				w.idle       = 1'b1;
				w.clr_i      = 1'b1;
				w.clr_best   = 1'b1;
				w.clr_recomp = 1'b1;
				w.jcond      = J_START;
				w.target     = ST_SCAN;
			end
			ST_SCAN: begin
				w.scan  = 1'b1;
				w.eval  = 1'b1;
				w.jcond = J_LOOP;
			end
			ST_CHECK: begin
				w.jcond  = J_RECOMP;
				w.target = ST_RINIT;
			end
			ST_EMIT: begin
				w.emit   = 1'b1;
				w.jcond  = J_OUT;
				w.target = ST_IDLE;
			end
			ST_RINIT: begin
				w.clr_i      = 1'b1;
				w.set_recomp = 1'b1;
				w.jcond      = J_NEXT;
			end
			ST_RECOMP: begin
				w.scan  = 1'b1;
				w.wback = 1'b1;
				w.jcond = J_LOOP;
			end
			ST_RESCAN: begin
				w.clr_i    = 1'b1;
				w.clr_best = 1'b1;
				w.jcond    = J_ALWAYS;
				w.target   = ST_SCAN;
			end
			default: begin
				w = CW_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/cptp_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
module cptp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/cptp_seq.sv -----
// microcode sequencer: step counter, control rom and jump logic
// depends on cptp_pkg
module cptp_seq
	import cptp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  status_t    st,
	output ctrl_word_t cw
);

	step_t upc_q;
	step_t upc_nxt;

	assign cw = ucode_rom(upc_q);

	always_comb begin
		upc_nxt = upc_q + 3'd1;
		case (cw.jcond)
			J_NEXT:   upc_nxt = upc_q + 3'd1;
			J_ALWAYS: upc_nxt = cw.target;
			J_START:  upc_nxt = start ? cw.target : upc_q;
			J_LOOP:   upc_nxt = st.more ? upc_q : upc_q + 3'd1;
			J_RECOMP: upc_nxt = st.need_recomp ? cw.target : upc_q + 3'd1;
			J_OUT:    upc_nxt = st.out_free ? cw.target : upc_q;
			default:  upc_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

// ----- hw/rtl/cptp_dp.sv -----
// datapath: task table ram with valid bits, slot pointer, best-candidate
// registers, counter recompute and the result register; depends on cptp_pkg, cptp_ram
module cptp_dp
	import cptp_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_word_t cw,
	input  cmd_t       cmd,
	input  logic       slot_we,
	input  logic [6:0] active_tasks,
	output status_t    st,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CTR_W = ($clog2(MAX_TASKS + 1) > 7) ? $clog2(MAX_TASKS + 1) : 7;

	logic [CTR_W-1:0]     scan_i_q;
	logic [CTR_W-1:0]     limit;
	logic                 more;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_ok;
	logic [IDX_W-1:0]     wr_idx;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [SLOT_W-1:0]    ram_wdata;
	logic [SLOT_W-1:0]    ram_rdata;
	logic [MAX_TASKS-1:0] valid_q;
	logic                 rd_vld_s1;
	logic                 pipe_v_s1;
	logic [IDX_W-1:0]     pipe_idx_s1;
	slot_t                entry;
	slot_t                wb_entry;
	logic                 cand;
	logic                 better;
	logic [8:0]           half_sum;
	logic                 wb_en;
	logic                 found_q;
	logic [7:0]           best_cnt_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic                 recomp_q;
	logic [IDX_W-1:0]     current_q;
	logic [IDX_W-1:0]     chosen;
	logic                 out_free;
	logic                 emit_go;
	logic                 res_valid_q;
	res_t                 res_q;

	// scan range is the register clipped to the table size
	assign limit = (CTR_W'(active_tasks) > CTR_W'(MAX_TASKS)) ?
		CTR_W'(MAX_TASKS) : CTR_W'(active_tasks);
	assign more    = scan_i_q < limit;
	assign rd_en   = cw.scan & more;
	assign rd_addr = scan_i_q[IDX_W-1:0];

	assign wr_ok  = slot_we && (32'(cmd.task_index) < 32'(MAX_TASKS));
	assign wr_idx = IDX_W'(cmd.task_index);

	// never-written entries read as the reset entry
	assign entry = rd_vld_s1 ? slot_t'(ram_rdata) : SLOT_RESET;
	assign cand  = pipe_v_s1 & entry.present & entry.started;
	assign better = cand && (!found_q || (entry.counter > best_cnt_q));

	assign half_sum = 9'(entry.counter >> 1) + 9'(entry.prio);
	always_comb begin
		wb_entry = entry;
		wb_entry.counter = half_sum[8] ? 8'hFF : half_sum[7:0];
	end
	assign wb_en = cw.wback & pipe_v_s1 & entry.present;

	// write commands only arrive at the idle step, write-backs only during recompute
	assign ram_we    = wr_ok | wb_en;
	assign ram_waddr = wb_en ? pipe_idx_s1 : wr_idx;
	assign ram_wdata = wb_en ? SLOT_W'(wb_entry) :
		SLOT_W'({cmd.task_present, cmd.task_started, cmd.task_priority, cmd.task_counter});

	cptp_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_TASKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign out_free = !res_valid_q | res_ready;
	assign emit_go  = cw.emit & out_free;
	assign chosen   = found_q ? best_idx_q : '0;

	assign st.more        = more;
	assign st.need_recomp = found_q && (best_cnt_q == 8'd0) && !recomp_q;
	assign st.out_free    = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			scan_i_q    <= '0;
			pipe_v_s1   <= 1'b0;
			found_q     <= 1'b0;
			recomp_q    <= 1'b0;
			current_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (cw.clr_i) begin
				scan_i_q <= '0;
			end else if (rd_en) begin
				scan_i_q <= scan_i_q + CTR_W'(1);
			end
			pipe_v_s1 <= rd_en;
			if (cw.clr_best) begin
				found_q <= 1'b0;
			end else if (cw.eval && better) begin
				found_q <= 1'b1;
			end
			if (cw.clr_recomp) begin
				recomp_q <= 1'b0;
			end else if (cw.set_recomp) begin
				recomp_q <= 1'b1;
			end
			if (emit_go) begin
				current_q   <= chosen;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_vld_s1   <= valid_q[rd_addr];
			pipe_idx_s1 <= rd_addr;
		end
		if (cw.eval && better) begin
			best_cnt_q <= entry.counter;
			best_idx_q <= pipe_idx_s1;
		end
		if (emit_go) begin
			res_q.chosen_task   <= 6'(chosen);
			res_q.switched      <= chosen != current_q;
			res_q.none_runnable <= !found_q;
			res_q.recomputed    <= recomp_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- hw/rtl/counter_priority_task_picker_core.sv -----
// Counter/priority task picker. A write beat (command 0) loads one task table slot. A
// schedule beat (command 1) sweeps slots 0 .. n-1, n being active_tasks clipped to
// MAX_TASKS, one slot per cycle through the single read port of the table ram, and returns
// the started task with the largest counter (lowest index on a tie). When every started
// counter is zero, the counters are recomputed (counter/2 + priority, saturated at 255)
// before a second sweep. The table reads as empty after reset; no clearing pass is needed.
// Write beats are taken while a result still waits in the output register; a schedule beat
// is taken only when the sequencer is idle.
// depends on cptp_pkg, cptp_seq, cptp_dp, cptp_ram
module counter_priority_task_picker_core
	import cptp_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);

	ctrl_word_t cw;
	status_t    st;
	logic       start;
	logic       slot_we;
	logic [6:0] active_q;

	assign cmd_ready = cw.idle;
	assign start     = cmd_valid & (cmd.command == CMD_SCHED);
	assign slot_we   = cmd_valid & cw.idle & (cmd.command == CMD_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 7'd1;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	cptp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cw     (cw)
	);

	cptp_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cw           (cw),
		.cmd          (cmd),
		.slot_we      (slot_we),
		.active_tasks (active_q),
		.st           (st),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

endmodule

// ----- tb/tb_counter_priority_task_picker_core.sv -----
`timescale 1ns / 1ps
// self-checking bench for counter_priority_task_picker_core: slot writes and schedule beats,
// each decision compared with a behavioral copy of the task table kept in a scoreboard class
// depends on cptp_pkg and counter_priority_task_picker_core
import cptp_pkg::*;

class pick_scoreboard;
	bit       present[MAX_TASKS_DEF];
	bit       started[MAX_TASKS_DEF];
	bit [6:0] prio[MAX_TASKS_DEF];
	bit [7:0] count[MAX_TASKS_DEF];
	bit [5:0] current;
	bit [6:0] active;
	res_t     pending_picks[$];
	int       errors;

	function new();
		foreach (prio[i]) prio[i] = 7'd1;
		active = 7'd1;
	endfunction

	function void set_active(logic [6:0] v);
		active = v;
	endfunction

	function int span();
		return (active > MAX_TASKS_DEF) ? MAX_TASKS_DEF : int'(active);
	endfunction

	// started and present slot with the largest counter, lowest index on a tie
	function bit find_best(output int best_idx, output int best_cnt);
		bit found;
		found = 1'b0;
		best_idx = 0;
		best_cnt = 0;
		for (int i = 0; i < span(); i++) begin
			if (present[i] && started[i] && (!found || count[i] > best_cnt)) begin
				found = 1'b1;
				best_idx = i;
				best_cnt = count[i];
			end
		end
		return found;
	endfunction

	function void note_command(cmd_t c);
		res_t e;
		int   idx;
		int   cnt;
		int   sum;
		bit   found;
		if (c.command == CMD_WRITE) begin
			present[c.task_index] = c.task_present;
			started[c.task_index] = c.task_started;
			prio[c.task_index] = c.task_priority;
			count[c.task_index] = c.task_counter;
			return;
		end
		e = '0;
		found = find_best(idx, cnt);
		if (found && cnt == 0) begin
			for (int i = 0; i < span(); i++) begin
				if (present[i]) begin
					sum = (count[i] >> 1) + prio[i];
					count[i] = (sum > 255) ? 8'd255 : 8'(sum);
				end
			end
			e.recomputed = 1'b1;
			found = find_best(idx, cnt);
		end
		e.chosen_task = found ? idx[5:0] : 6'd0;
		e.none_runnable = !found;
		e.switched = (e.chosen_task != current);
		current = e.chosen_task;
		pending_picks.push_back(e);
	endfunction

	function void check_decision(res_t r);
		res_t e;
		if (pending_picks.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, got %h", $time, r);
			errors++;
			return;
		end
		e = pending_picks.pop_front();
		if (r.chosen_task != e.chosen_task) begin
			$display("%0t: chosen_task expected %0d got %0d", $time, e.chosen_task,
				r.chosen_task);
			errors++;
		end
		if (r.switched != e.switched) begin
			$display("%0t: switched expected %0d got %0d", $time, e.switched, r.switched);
			errors++;
		end
		if (r.none_runnable != e.none_runnable) begin
			$display("%0t: none_runnable expected %0d got %0d", $time, e.none_runnable,
				r.none_runnable);
			errors++;
		end
		if (r.recomputed != e.recomputed) begin
			$display("%0t: recomputed expected %0d got %0d", $time, e.recomputed,
				r.recomputed);
			errors++;
		end
	endfunction
endclass

module tb_counter_priority_task_picker_core;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD = 1500;
	localparam logic [6:0] ACTIVE_STEPS [10] = '{7'd64, 7'd127, 7'd3, 7'd65, 7'd16, 7'd1,
		7'd0, 7'd40, 7'd2, 7'd64};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	cmd_t       cmd = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_t       res;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	pick_scoreboard board = new();
	int  cycles = 0;
	int  scan_span = 1;
	bit  send_calm = 1'b0;
	bit  sink_calm = 1'b0;

	counter_priority_task_picker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("counter_priority_task_picker_core test failed");
			$finish;
		end
	end

	// config writes, accepted commands and result beats as seen at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				board.set_active(cfg_wdata);
			if (cmd_valid && cmd_ready)
				board.note_command(cmd);
			if (res_valid && res_ready)
				board.check_decision(res);
		end
	end

	// result sink with random stalls and two long hold-offs to back up the input
	initial begin : result_sink
		int hold;
		int taken;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken == 30 || taken == 250)
				hold = LONG_HOLD;
			else if (sink_calm)
				hold = 0;
			else
				hold = $urandom_range(0, 5);
			if ($urandom_range(0, 39) == 0)
				sink_calm = !sink_calm;
			if (hold > 0) begin
				res_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			taken++;
		end
	end

	task automatic send_cmd(input cmd_t c);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 5);
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// wait until every decision has come back and the block has gone quiet
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_picks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_active(input logic [6:0] v);
		settle();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		scan_span = (v > MAX_TASKS_DEF) ? MAX_TASKS_DEF : int'(v);
	endtask

	function automatic cmd_t slot_write(int idx, bit p, bit s, int pr, int cnt);
		cmd_t c;
		c.command = CMD_WRITE;
		c.task_index = idx[5:0];
		c.task_present = p;
		c.task_started = s;
		c.task_priority = pr[6:0];
		c.task_counter = cnt[7:0];
		return c;
	endfunction

	// slot fields ride along with random content on a schedule beat
	function automatic cmd_t sched_beat();
		logic [31:0] bits;
		cmd_t        c;
		bits = $urandom;
		c = bits[$bits(cmd_t)-1:0];
		c.command = CMD_SCHED;
		return c;
	endfunction

	function automatic cmd_t random_write(int span);
		logic [31:0] bits;
		cmd_t        c;
		int          r;
		bits = $urandom;
		c = bits[$bits(cmd_t)-1:0];
		c.command = CMD_WRITE;
		if (span > 0 && $urandom_range(0, 4) != 0)
			c.task_index = 6'($urandom_range(0, span - 1));
		c.task_present = ($urandom_range(0, 7) != 0);
		c.task_started = ($urandom_range(0, 9) < 6);
		r = $urandom_range(0, 9);
		c.task_priority = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(1, 127));
		r = $urandom_range(0, 19);
		c.task_counter = (r < 9) ? 8'd0 : (r < 11) ? 8'd255 : 8'($urandom);
		return c;
	endfunction

	task automatic random_run(input int budget);
		int   sent;
		int   k;
		bit   drain;
		cmd_t c;
		sent = 0;
		while (sent < budget) begin
			if (scan_span > 0 && $urandom_range(0, 99) < 8) begin
				// reload the whole scanned range, usually with drained counters, then decide
				drain = ($urandom_range(0, 3) != 0);
				for (int i = 0; i < scan_span; i++) begin
					c = random_write(scan_span);
					c.task_index = i[5:0];
					if (drain)
						c.task_counter = 8'd0;
					send_cmd(c);
				end
				k = $urandom_range(1, 3);
				repeat (k) send_cmd(sched_beat());
				sent += scan_span + k;
			end else begin
				if ($urandom_range(0, 99) < 30)
					send_cmd(sched_beat());
				else
					send_cmd(random_write(scan_span));
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one slot scanned after reset: empty table, then a drained counter
		send_cmd(sched_beat());
		send_cmd(slot_write(0, 1, 1, 1, 0));
		send_cmd(slot_write(1, 1, 1, 127, 255));
		send_cmd(sched_beat());

		load_active(7'd64);
		send_cmd(slot_write(63, 1, 1, 127, 255));
		send_cmd(slot_write(5, 0, 1, 127, 255));
		// tie with slots 1 and 63, lowest index wins
		send_cmd(slot_write(10, 1, 1, 3, 255));
		send_cmd(sched_beat());
		send_cmd(slot_write(0, 1, 1, 1, 0));
		send_cmd(slot_write(10, 1, 1, 0, 0));
		send_cmd(slot_write(63, 1, 1, 127, 0));
		send_cmd(slot_write(20, 1, 0, 127, 255));
		send_cmd(sched_beat());
		// zero priorities and zero counters on slots 63 and 0 before another decision
		send_cmd(slot_write(63, 1, 1, 0, 0));
		send_cmd(slot_write(0, 1, 1, 0, 0));
		send_cmd(sched_beat());
		send_cmd(slot_write(0, 0, 0, 1, 0));
		send_cmd(slot_write(10, 0, 0, 1, 0));
		send_cmd(slot_write(63, 0, 0, 1, 0));
		send_cmd(sched_beat());

		// nothing scanned at all
		load_active(7'd0);
		send_cmd(slot_write(3, 1, 1, 5, 9));
		send_cmd(sched_beat());

		foreach (ACTIVE_STEPS[p]) begin
			load_active(ACTIVE_STEPS[p]);
			random_run(160);
		end

		settle();
		if (board.errors == 0 && board.pending_picks.size() == 0)
			$display("counter_priority_task_picker_core test passed");
		else
			$display("counter_priority_task_picker_core test failed");
		$finish;
	end
endmodule

// ----- files.f -----
hw/rtl/cptp_pkg.sv
hw/rtl/cptp_ram.sv
hw/rtl/cptp_seq.sv
hw/rtl/cptp_dp.sv
hw/rtl/counter_priority_task_picker_core.sv
tb/tb_counter_priority_task_picker_core.sv
